// ===== hdl/ks_pkg.sv =====
// Shared types, constants and arithmetic helpers of the plucked-string voice.
package ks_pkg;

    localparam int SAMPLE_W = 16;
    localparam int WIDE_W   = 19;
    localparam int FACTOR_W = 16;
    localparam int LEN_W    = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [WIDE_W-1:0]   t_wide;
    typedef logic [FACTOR_W-1:0]        t_factor;
    typedef logic [LEN_W-1:0]           t_len;
    typedef logic [CFG_IDX_W-1:0]       t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]      t_cfg_data;

    localparam t_cfg_idx CFG_STRING_LENGTH     = 2'd0;
    localparam t_cfg_idx CFG_LOSS_FACTOR       = 2'd1;
    localparam t_cfg_idx CFG_EXCITE_BRIGHTNESS = 2'd2;

    localparam logic CMD_EXCITE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam t_len    RST_STRING_LENGTH     = 13'd2;
    localparam t_factor RST_LOSS_FACTOR       = 16'd65470;
    localparam t_factor RST_EXCITE_BRIGHTNESS = 16'd13107;

    localparam t_factor OUT_GAIN  = 16'd62259;
    localparam t_factor MUTE_GAIN = 16'd65438;

    localparam t_wide SAMPLE_MAX = 19'sd32767;
    localparam t_wide SAMPLE_MIN = -19'sd32768;

    function automatic t_sample sat_sample(input t_wide v);
        t_sample res;
        if (v > SAMPLE_MAX) begin
            res = 16'sh7fff;
        end else if (v < SAMPLE_MIN) begin
            res = 16'sh8000;
        end else begin
            res = v[SAMPLE_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hdl/ks_in_if.sv =====
// Input channel of the plucked-string voice: command items with valid/ready.
interface ks_in_if;
    import ks_pkg::*;

    logic    valid;
    logic    ready;
    logic    command;
    t_sample noise_sample;
    logic    first_of_burst;
    logic    muted;

    modport source (output valid, output command, output noise_sample,
                    output first_of_burst, output muted, input ready);
    modport sink   (input valid, input command, input noise_sample,
                    input first_of_burst, input muted, output ready);
endinterface

// ===== hdl/ks_out_if.sv =====
// Output channel of the plucked-string voice: audio samples with valid/ready.
interface ks_out_if;
    import ks_pkg::*;

    logic    valid;
    logic    ready;
    t_sample audio_sample;

    modport source (output valid, output audio_sample, input ready);
    modport sink   (input valid, input audio_sample, output ready);
endinterface

// ===== hdl/ks_line.sv =====
// Delay line memory with one write port and one registered read port.
module ks_line #(
    parameter int LINE_DEPTH = 8192
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [$clog2(LINE_DEPTH)-1:0] i_waddr,
    input  ks_pkg::t_sample               i_wdata,
    input  logic                          i_re,
    input  logic [$clog2(LINE_DEPTH)-1:0] i_raddr,
    output ks_pkg::t_sample               o_rdata
);
    import ks_pkg::*;

    t_sample r_mem [LINE_DEPTH];
    t_sample r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/karplus_strong_string.sv =====
// Top level of the plucked-string voice: control, filter, feedback and output stage.
//
// Excite transfers load one lowpass-filtered noise sample into the delay line;
// tick transfers make two reads of the line memory's single read port, then the
// write-back, and return one audio sample each. An item is taken only while no
// earlier item is in progress, and a tick whose result cannot enter the output
// register waits in its last cycle. The output register holds one finished
// sample, so the next item is taken while it waits.
// Configuration writes are taken at any time but must only be made while idle.
module karplus_strong_string #(
    parameter int LINE_DEPTH = 8192
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  ks_pkg::t_cfg_idx  i_cfg_idx,
    input  ks_pkg::t_cfg_data i_cfg_wdata,
    ks_in_if.sink             i_in,
    ks_out_if.source          o_out
);
    import ks_pkg::*;

    localparam int PW = $clog2(LINE_DEPTH);
    localparam int LW = (PW > LEN_W) ? PW : LEN_W;
    localparam logic [LW-1:0] MAX_LEN = LW'(LINE_DEPTH - 1);
    localparam logic [LW-1:0] MIN_LEN = LW'(2);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXCITE,
        S_TICK_RD,
        S_TICK_CALC
    } t_state;

    t_state  r_state;
    t_len    r_str_len;
    t_factor r_loss;
    t_factor r_bright;
    logic [PW-1:0] r_rd_pos;
    logic [PW-1:0] r_load;
    logic [PW-1:0] r_pos;
    logic [PW-1:0] r_next;
    t_sample r_filt;
    t_sample r_noise;
    logic    r_first;
    logic    r_muted;
    t_sample r_cur;
    t_factor r_damp;
    t_sample r_y;
    logic    r_out_valid;
    t_sample r_audio;

    logic [LW-1:0] len_ext;
    logic [LW-1:0] eff_len;
    logic [LW-1:0] rp_ext;
    logic [LW-1:0] pos_c;
    logic [LW-1:0] pos_inc;
    logic [LW-1:0] next_c;
    logic [LW-1:0] ld_ext;
    logic [LW-1:0] idx_c;
    logic [LW-1:0] idx_inc;
    logic [LW-1:0] load_c;
    logic          accept;
    logic          out_free;

    t_sample             filt_base;
    logic signed [16:0]  diff;
    logic signed [33:0]  eprod;
    t_wide               esum;
    t_sample             n_filt;
    logic signed [32:0]  oprod;
    t_sample             n_y;
    logic [31:0]         mprod;
    t_factor             n_damp;
    logic signed [16:0]  lsum;
    t_sample             avg;
    logic signed [32:0]  fprod;
    t_sample             fed;

    logic          mem_we;
    logic [PW-1:0] mem_waddr;
    t_sample       mem_wdata;
    logic          mem_re;
    logic [PW-1:0] mem_raddr;
    t_sample       mem_rdata;

    // Effective length and position bookkeeping.
    always_comb begin
        len_ext = LW'(r_str_len);
        if (len_ext < MIN_LEN) begin
            eff_len = MIN_LEN;
        end else if (len_ext > MAX_LEN) begin
            eff_len = MAX_LEN;
        end else begin
            eff_len = len_ext;
        end
        rp_ext  = LW'(r_rd_pos);
        pos_c   = (rp_ext >= eff_len) ? '0 : rp_ext;
        pos_inc = pos_c + LW'(1);
        next_c  = (pos_inc >= eff_len) ? '0 : pos_inc;
        ld_ext  = i_in.first_of_burst ? '0 : LW'(r_load);
        idx_c   = (ld_ext >= eff_len) ? '0 : ld_ext;
        idx_inc = idx_c + LW'(1);
        load_c  = (idx_inc >= eff_len) ? '0 : idx_inc;
    end

    // Excitation lowpass.
    always_comb begin
        filt_base = r_first ? '0 : r_filt;
        diff      = {r_noise[SAMPLE_W-1], r_noise} - {filt_base[SAMPLE_W-1], filt_base};
        eprod     = diff * $signed({1'b0, r_bright});
        esum      = {{3{filt_base[SAMPLE_W-1]}}, filt_base} + {eprod[33], eprod[33:16]};
        n_filt    = sat_sample(esum);
    end

    // Output gain and damping factor, from the first line read.
    always_comb begin
        oprod  = mem_rdata * $signed({1'b0, OUT_GAIN});
        n_y    = sat_sample({{2{oprod[32]}}, oprod[32:16]});
        mprod  = r_loss * MUTE_GAIN;
        n_damp = r_muted ? mprod[31:16] : r_loss;
    end

    // Feedback: average of the two neighbors, scaled by the damping factor.
    always_comb begin
        lsum  = {r_cur[SAMPLE_W-1], r_cur} + {mem_rdata[SAMPLE_W-1], mem_rdata};
        avg   = lsum[16:1];
        fprod = avg * $signed({1'b0, r_damp});
        fed   = sat_sample({{2{fprod[32]}}, fprod[32:16]});
    end

    assign accept   = i_in.valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || o_out.ready;

    always_comb begin
        mem_we    = (r_state == S_EXCITE) || ((r_state == S_TICK_CALC) && out_free);
        mem_waddr = r_pos;
        mem_wdata = (r_state == S_EXCITE) ? n_filt : fed;
        mem_re    = (accept && (i_in.command == CMD_TICK)) || (r_state == S_TICK_RD);
        mem_raddr = (r_state == S_TICK_RD) ? r_next : pos_c[PW-1:0];
    end

    ks_line #(
        .LINE_DEPTH(LINE_DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_str_len   <= RST_STRING_LENGTH;
            r_loss      <= RST_LOSS_FACTOR;
            r_bright    <= RST_EXCITE_BRIGHTNESS;
            r_rd_pos    <= '0;
            r_load      <= '0;
            r_filt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_STRING_LENGTH:     r_str_len <= i_cfg_wdata[LEN_W-1:0];
                    CFG_LOSS_FACTOR:       r_loss    <= i_cfg_wdata;
                    CFG_EXCITE_BRIGHTNESS: r_bright  <= i_cfg_wdata;
                    default: ;
                endcase
            end

            if (o_out.ready && !((r_state == S_TICK_CALC) && out_free)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_muted <= i_in.muted;
                        r_noise <= i_in.noise_sample;
                        r_first <= i_in.first_of_burst;
                        if (i_in.command == CMD_TICK) begin
                            r_pos    <= pos_c[PW-1:0];
                            r_next   <= next_c[PW-1:0];
                            r_rd_pos <= next_c[PW-1:0];
                            r_state  <= S_TICK_RD;
                        end else begin
                            r_pos   <= idx_c[PW-1:0];
                            r_load  <= load_c[PW-1:0];
                            if (i_in.first_of_burst) begin
                                r_rd_pos <= '0;
                            end
                            r_state <= S_EXCITE;
                        end
                    end
                end
                S_EXCITE: begin
                    r_filt  <= n_filt;
                    r_state <= S_IDLE;
                end
                S_TICK_RD: begin
                    r_cur   <= mem_rdata;
                    r_y     <= n_y;
                    r_damp  <= n_damp;
                    r_state <= S_TICK_CALC;
                end
                S_TICK_CALC: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_audio     <= r_y;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.audio_sample = r_audio;
endmodule
